FILE: rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

  // Pool geometry
  localparam int NUM_STACKS = 4;
  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int SID_W      = 2;
  localparam int VAL_W      = 32;

  // Null link is the index one past the pool
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

  // Commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic signed [VAL_W-1:0] UNDERFLOW_VALUE = '1;

  typedef struct packed {
    logic                    command;
    logic [SID_W-1:0]        stack_id;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pop_value;
    logic [1:0]              status;
    logic                    pool_full;
    logic                    stack_empty;
  } out_item_t;

endpackage

FILE: rtl/msp_ram.sv
`timescale 1ns / 1ps

module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/msp_link_store.sv
`timescale 1ns / 1ps

// Link store: RAM plus a valid bit per entry; unwritten entry i reads i+1.
module msp_link_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       re,
  input  logic [msp_pkg::IDX_W-1:0]  raddr,
  output logic [msp_pkg::LINK_W-1:0] rdata,
  input  logic                       we,
  input  logic [msp_pkg::IDX_W-1:0]  waddr,
  input  logic [msp_pkg::LINK_W-1:0] wdata
);

  logic [msp_pkg::POOL_DEPTH-1:0] vld_r;
  logic                           rd_vld_r;
  logic [msp_pkg::IDX_W-1:0]      rd_idx_r;
  logic [msp_pkg::LINK_W-1:0]     ram_q;

  msp_ram #(
    .WIDTH(msp_pkg::LINK_W),
    .DEPTH(msp_pkg::POOL_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_vld_r <= vld_r[raddr];
      rd_idx_r <= raddr;
    end
  end

  // Last entry's default (depth) is the null code
  assign rdata = rd_vld_r ? ram_q
                          : msp_pkg::LINK_W'(rd_idx_r) + msp_pkg::LINK_W'(1);

endmodule

FILE: rtl/multi_stack_shared_pool_top.sv
`timescale 1ns / 1ps

// Several stacks sharing one pool of entries, with unused entries on a free
// list. Each transfer on the input channel is one push or pop and yields one
// transfer on the result channel. The link and value stores are read
// synchronously in S_RD and the result register loads at the write-back in
// S_WB; the input side is ready again straight after the write-back, so a
// new item is only taken once the last is through; the dependent read of
// the link store behind the stack top or free head is the reason.
// A result still waiting on out_ready does not block the next input transfer;
// only the write-back of that next item waits for the result register to
// empty. No clearing pass after reset: link defaults come from per-entry
// valid bits, and values are only read after being pushed.
module multi_stack_shared_pool_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msp_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msp_pkg::out_item_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Latched item
  logic                            cmd_r;
  logic [msp_pkg::SID_W-1:0]       sid_r;
  logic signed [msp_pkg::VAL_W-1:0] val_r;

  // Pool control state
  logic [msp_pkg::LINK_W-1:0] tops_r [msp_pkg::NUM_STACKS];
  logic [msp_pkg::LINK_W-1:0] free_head_r;

  // Result register
  logic               out_valid_r;
  msp_pkg::out_item_t out_data_r;

  logic [msp_pkg::LINK_W-1:0] top_sel;
  logic                       valid_stack;
  logic                       top_null;
  logic                       free_null;
  logic                       op_err;
  logic                       out_free;
  logic                       wb_go;
  logic                       commit;
  logic [msp_pkg::LINK_W-1:0] slot;
  logic [msp_pkg::LINK_W-1:0] link_q;
  logic                       link_q_null;
  logic [msp_pkg::VAL_W-1:0]  value_q;
  logic [msp_pkg::LINK_W-1:0] new_top;
  msp_pkg::out_item_t         res;

  // Top of the addressed stack
  always_comb begin
    top_sel = msp_pkg::NULL_LINK;
    for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
      if (32'(sid_r) == i) begin
        top_sel = tops_r[i];
      end
    end
  end

  assign valid_stack = (32'(sid_r) < msp_pkg::NUM_STACKS);
  assign top_null    = (top_sel >= msp_pkg::NULL_LINK);
  assign free_null   = (free_head_r >= msp_pkg::NULL_LINK);
  assign op_err      = (cmd_r == msp_pkg::CMD_PUSH) ? (!valid_stack || free_null)
                                                    : (!valid_stack || top_null);

  // Entry being moved: free head on push, stack top on pop
  assign slot        = (cmd_r == msp_pkg::CMD_PUSH) ? free_head_r : top_sel;
  assign link_q_null = (link_q >= msp_pkg::NULL_LINK);

  assign out_free = !out_valid_r || out_ready;
  assign wb_go    = (state_r == S_WB) && out_free;
  assign commit   = wb_go && !op_err;
  assign new_top  = (cmd_r == msp_pkg::CMD_PUSH) ? slot : link_q;

  // Link store and value store, both read in S_RD at the moved entry
  msp_link_store u_links (
    .clk  (clk),
    .rst_n(rst_n),
    .re   (state_r == S_RD),
    .raddr(slot[msp_pkg::IDX_W-1:0]),
    .rdata(link_q),
    .we   (commit),
    .waddr(slot[msp_pkg::IDX_W-1:0]),
    .wdata((cmd_r == msp_pkg::CMD_PUSH) ? top_sel : free_head_r)
  );

  msp_ram #(
    .WIDTH(msp_pkg::VAL_W),
    .DEPTH(msp_pkg::POOL_DEPTH)
  ) u_values (
    .clk  (clk),
    .we   (commit && (cmd_r == msp_pkg::CMD_PUSH)),
    .waddr(slot[msp_pkg::IDX_W-1:0]),
    .wdata(val_r),
    .re   (state_r == S_RD),
    .raddr(slot[msp_pkg::IDX_W-1:0]),
    .rdata(value_q)
  );

  // Result fields as the pool stands after the operation
  always_comb begin
    res.pop_value   = '0;
    res.status      = msp_pkg::ST_OK;
    res.pool_full   = free_null;
    res.stack_empty = !valid_stack || top_null;
    if (op_err) begin
      if (cmd_r == msp_pkg::CMD_PUSH) begin
        res.status = msp_pkg::ST_OVERFLOW;
      end else begin
        res.status    = msp_pkg::ST_UNDERFLOW;
        res.pop_value = msp_pkg::UNDERFLOW_VALUE;
      end
    end else if (cmd_r == msp_pkg::CMD_PUSH) begin
      res.pool_full   = link_q_null;
      res.stack_empty = 1'b0;
    end else begin
      res.pop_value   = value_q;
      res.pool_full   = 1'b0;
      res.stack_empty = link_q_null;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_WB;
      S_WB:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data.command;
      sid_r <= in_data.stack_id;
      val_r <= in_data.push_value;
    end
  end

  // Free head and stack tops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
        tops_r[i] <= msp_pkg::NULL_LINK;
      end
    end else if (commit) begin
      free_head_r <= (cmd_r == msp_pkg::CMD_PUSH) ? link_q : slot;
      for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
        if (32'(sid_r) == i) begin
          tops_r[i] <= new_top;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_data_r <= res;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/msp_checker.sv
`timescale 1ns / 1ps

module msp_checker
  import msp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        awaiting,
  output int        cmds_taken,
  output int        results_seen,
  output int        overflows,
  output int        underflows
);

  // shadow of the pool
  logic signed [VAL_W-1:0] slot_val  [POOL_DEPTH];
  logic [LINK_W-1:0]       slot_next [POOL_DEPTH];
  logic [LINK_W-1:0]       top_of    [NUM_STACKS];
  logic [LINK_W-1:0]       free_ptr;

  out_item_t predicted_out [$];
  out_item_t head_exp;
  int        errs;
  int        n_cmds;
  int        n_res;
  int        n_ovf;
  int        n_udf;

  function automatic logic is_null(input logic [LINK_W-1:0] idx);
    return int'(idx) >= POOL_DEPTH;
  endfunction

  // one push or pop against the shadow; returns the result it should give
  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t         r;
    logic [LINK_W-1:0] slot;
    logic              known;
    r        = '0;
    r.status = ST_OK;
    known    = int'(c.stack_id) < NUM_STACKS;
    if (c.command == CMD_PUSH) begin
      if (!known || is_null(free_ptr)) begin
        r.status = ST_OVERFLOW;
      end else begin
        slot              = free_ptr;
        free_ptr          = slot_next[slot];
        slot_val[slot]    = c.push_value;
        slot_next[slot]   = top_of[c.stack_id];
        top_of[c.stack_id] = slot;
      end
    end else begin
      if (!known || is_null(top_of[c.stack_id])) begin
        r.status    = ST_UNDERFLOW;
        r.pop_value = UNDERFLOW_VALUE;
      end else begin
        slot               = top_of[c.stack_id];
        top_of[c.stack_id] = slot_next[slot];
        slot_next[slot]    = free_ptr;
        free_ptr           = slot;
        r.pop_value        = slot_val[slot];
      end
    end
    r.pool_full   = is_null(free_ptr);
    r.stack_empty = !known || is_null(top_of[c.stack_id]);
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] seen);
    $display("%0t: %s expected %0h got %0h", $time, field, want, seen);
    errs++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        slot_val[i]  = '0;
        slot_next[i] = (i == POOL_DEPTH - 1) ? NULL_LINK : LINK_W'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) top_of[s] = NULL_LINK;
      free_ptr = '0;
      predicted_out.delete();
      errs   = 0;
      n_cmds = 0;
      n_res  = 0;
      n_ovf  = 0;
      n_udf  = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_res++;
        if (predicted_out.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          errs++;
        end else begin
          head_exp = predicted_out.pop_front();
          if (out_data.pop_value !== head_exp.pop_value)
            flag("pop_value", head_exp.pop_value, out_data.pop_value);
          if (out_data.status !== head_exp.status)
            flag("status", 32'(head_exp.status), 32'(out_data.status));
          if (out_data.pool_full !== head_exp.pool_full)
            flag("pool_full", 32'(head_exp.pool_full), 32'(out_data.pool_full));
          if (out_data.stack_empty !== head_exp.stack_empty)
            flag("stack_empty", 32'(head_exp.stack_empty), 32'(out_data.stack_empty));
        end
      end
      if (in_valid && in_ready) begin
        n_cmds++;
        head_exp = apply_command(in_data);
        if (head_exp.status == ST_OVERFLOW) n_ovf++;
        if (head_exp.status == ST_UNDERFLOW) n_udf++;
        predicted_out.push_back(head_exp);
      end
    end
    mismatches   <= errs;
    awaiting     <= predicted_out.size();
    cmds_taken   <= n_cmds;
    results_seen <= n_res;
    overflows    <= n_ovf;
    underflows   <= n_udf;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the shared-pool stack block. The checker beside
// the block does all prediction and comparison; this module only drives the
// two channels, applies back-pressure and decides pass or fail.
module tb;
  import msp_pkg::*;

  localparam int RAND_ITEMS  = 625;  // after the directed part
  localparam int BURST       = 25;   // random items per push/pop mix
  localparam int HOLD_AT     = 100;  // commands taken before the long stall
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000; // cycles with no transfer at all
  localparam int TAIL_CYCLES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int   mismatches;
  int   awaiting;
  int   cmds_taken;
  int   results_seen;
  int   overflows;
  int   underflows;
  logic gaps_on;
  int   quiet;

  logic signed [VAL_W-1:0] corners [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};

  multi_stack_shared_pool_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  msp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .cmds_taken   (cmds_taken),
    .results_seen (results_seen),
    .overflows    (overflows),
    .underflows   (underflows)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t make_cmd(input logic op, input logic [SID_W-1:0] sid,
                                        input logic signed [VAL_W-1:0] val);
    in_item_t c;
    c.command    = op;
    c.stack_id   = sid;
    c.push_value = val;
    return c;
  endfunction

  // Offer one command and hold it until the transfer. Idle cycles come
  // first, so valid only drops between commands, never while one is offered.
  task automatic offer(input in_item_t item);
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender goes quiet until every predicted result has come back.
  // The first edge lets the count catch up with the last transfer.
  task automatic wait_all_back();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off while the sender keeps
  // offering, so the block backs up and drops in_ready.
  initial begin
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && cmds_taken >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 14);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int                      push_pct;
    logic                    focus_on;
    logic [SID_W-1:0]        focus_sid;
    logic                    op;
    logic [SID_W-1:0]        sid;
    logic signed [VAL_W-1:0] val;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    gaps_on  <= 1'b1;
    push_pct  = 50;
    focus_on  = 1'b0;
    focus_sid = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pops on every empty stack (underflow), then fill the whole
    // pool across all stacks, starting with corner values, one push into the full pool
    // (overflow), a few pops, and a push that reuses a freed entry.
    for (int s = 0; s < NUM_STACKS; s++)
      offer(make_cmd(CMD_POP, SID_W'(s), $urandom));
    for (int i = 0; i < POOL_DEPTH; i++) begin
      case (i)
        0, 1, 2, 3: val = corners[i];
        4:          val = 32'sh5555_5555;
        5:          val = 32'shAAAA_AAAA;
        default:    val = $urandom;
      endcase
      offer(make_cmd(CMD_PUSH, SID_W'(i % NUM_STACKS), val));
    end
    offer(make_cmd(CMD_PUSH, 2'd2, 32'sh1234_5678));
    offer(make_cmd(CMD_POP, 2'd3, $urandom));
    offer(make_cmd(CMD_POP, 2'd3, $urandom));
    offer(make_cmd(CMD_POP, 2'd0, $urandom));
    offer(make_cmd(CMD_PUSH, 2'd1, -32'sd2));
    wait_all_back();

    // Random: bursts with a push-heavy, balanced or pop-heavy mix, often
    // aimed at one stack, so the pool repeatedly fills and drains.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % BURST == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        focus_on  = 1'($urandom_range(1));
        focus_sid = SID_W'($urandom_range(NUM_STACKS - 1));
      end
      if (n == 150) gaps_on <= 1'b0;  // long stretch at full rate
      if (n == 260) gaps_on <= 1'b1;
      if (n == 300) wait_all_back();
      op  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      sid = (focus_on && $urandom_range(3) != 0) ? focus_sid
                                                 : SID_W'($urandom_range(NUM_STACKS - 1));
      val = ($urandom_range(7) == 0) ? corners[$urandom_range(3)] : $urandom;
      offer(make_cmd(op, sid, val));
    end

    wait_all_back();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Ran %0d commands over %0d stacks; %0d results checked.",
             cmds_taken, NUM_STACKS, results_seen);
    $display("Hit %0d overflows and %0d underflows, with one long result stall.",
             overflows, underflows);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msp_pkg.sv
rtl/msp_ram.sv
rtl/msp_link_store.sv
rtl/multi_stack_shared_pool_top.sv
tb/msp_checker.sv
tb/tb.sv
